>>> rtl/core/rklm_pkg.sv
// rklm_pkg: shared types, codes and sizes for the remote key learn and match core
// used by the controller, the datapath, the top level and the port checker
`timescale 1ns / 1ps

package rklm_pkg;

   // table sizes
   localparam int KEY_SLOTS     = 5;
   localparam int REPEAT_FRAMES = 5;

   // field widths
   localparam int FRAME_W    = 32;
   localparam int KEY_W      = 20;
   localparam int CMD_LSB    = 8;
   localparam int IDX_W      = $clog2(KEY_SLOTS + 1);
   localparam int PROMPT_W   = 8;
   localparam int WINDOW_W   = 10;
   localparam int CSR_DATA_W = 10;
   localparam int CSR_IDX_W  = 1;

   // register reset values
   localparam logic [PROMPT_W-1:0] PROMPT_RESET = 8'd10;
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 10'd60;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PROMPT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW = 1'd1;

   // action codes
   localparam logic [1:0] ACT_FRAME      = 2'd0;
   localparam logic [1:0] ACT_TICK       = 2'd1;
   localparam logic [1:0] ACT_LEARN      = 2'd2;
   localparam logic [1:0] ACT_MOTOR_DONE = 2'd3;

   // lock positions
   localparam logic [1:0] LOCK_RAISED  = 2'd1;
   localparam logic [1:0] LOCK_LOWERED = 2'd2;

   // command nibbles
   localparam logic [3:0] CMD_LOWER = 4'h4;
   localparam logic [3:0] CMD_RAISE = 4'h1;

   // motor commands
   localparam logic [1:0] MOTOR_NONE  = 2'd0;
   localparam logic [1:0] MOTOR_LOWER = 2'd1;
   localparam logic [1:0] MOTOR_RAISE = 2'd2;

   // beep patterns
   localparam logic [2:0] BEEP_NONE     = 3'd0;
   localparam logic [2:0] BEEP_ACCEPTED = 3'd1;
   localparam logic [2:0] BEEP_LEARNED  = 3'd2;
   localparam logic [2:0] BEEP_PROMPT   = 3'd3;
   localparam logic [2:0] BEEP_OVER     = 3'd4;

   typedef struct packed {
      logic [1:0]         action;
      logic [FRAME_W-1:0] frame;
      logic [1:0]         lock_position;
      logic               at_power_up;
      logic [7:0]         learn_count;
   } req_type;

   typedef struct packed {
      logic [1:0] motor_command;
      logic [2:0] beep_pattern;
      logic       learning_active;
      logic       key_learned;
      logic [2:0] learned_slot;
      logic [2:0] keys_learned;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic check;
      logic commit;
   } ctrl_cmd_type;

endpackage

>>> rtl/core/remote_key_learn_and_match_core.sv
// remote_key_learn_and_match_core: top level of the learning remote key decoder
// depends on rklm_pkg, rklm_ctrl and rklm_dp
`timescale 1ns / 1ps

// Each transaction on req_ gives exactly one transaction on rsp_. A transaction
// passes through capture, checksum check, then the state update that writes
// the result register; these steps are sequenced by the controller, which takes
// one transaction at a time, so a new one is accepted only after the update step
// of the last. A result held by rsp_stall delays only the next update step, not
// the capture of the next transaction. The csr_ registers (prompt interval,
// learning window, in ticks) may be written while no transaction is in flight
// and take effect at the next timer load.
module remote_key_learn_and_match_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  rklm_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output rklm_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [rklm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rklm_pkg::CSR_DATA_W-1:0] csr_wdata
);

   rklm_pkg::ctrl_cmd_type cmd;

   // sequencing
   rklm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // datapath
   rklm_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/core/rklm_ctrl.sv
// rklm_ctrl: sequencing state machine and result handshake
// depends on rklm_pkg
`timescale 1ns / 1ps

module rklm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rklm_pkg::ctrl_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_COMMIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   // output register can take a new result this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/core/rklm_dp.sv
// rklm_dp: frame check, key table, frame history, timers and result register
// depends on rklm_pkg
`timescale 1ns / 1ps

module rklm_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  rklm_pkg::ctrl_cmd_type              cmd,
   input  rklm_pkg::req_type                   req_data,
   input  logic                                csr_we,
   input  logic [rklm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rklm_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output rklm_pkg::rsp_type                   rsp_data
);

   // configuration
   logic [rklm_pkg::PROMPT_W-1:0] prompt_int_ff;
   logic [rklm_pkg::WINDOW_W-1:0] window_len_ff;

   // captured transaction and checked frame
   rklm_pkg::req_type             req_ff;
   logic [rklm_pkg::FRAME_W-1:0]  checked_ff;
   logic [rklm_pkg::FRAME_W-1:0]  checked_in;
   logic [7:0]                    sum8;

   // learning state
   logic [rklm_pkg::KEY_W-1:0]    key_tab_ff [rklm_pkg::KEY_SLOTS];
   logic [rklm_pkg::KEY_W-1:0]    key_tab_in [rklm_pkg::KEY_SLOTS];
   logic [rklm_pkg::FRAME_W-1:0]  hist_ff    [rklm_pkg::REPEAT_FRAMES];
   logic [rklm_pkg::FRAME_W-1:0]  hist_in    [rklm_pkg::REPEAT_FRAMES];
   logic [rklm_pkg::IDX_W-1:0]    target_ff;
   logic [rklm_pkg::IDX_W-1:0]    target_in;
   logic [rklm_pkg::IDX_W-1:0]    index_ff;
   logic [rklm_pkg::IDX_W-1:0]    index_in;
   logic                          learning_ff;
   logic                          learning_in;
   logic                          motor_busy_ff;
   logic                          motor_busy_in;
   logic [rklm_pkg::PROMPT_W-1:0] prompt_tmr_ff;
   logic [rklm_pkg::PROMPT_W-1:0] prompt_tmr_in;
   logic [rklm_pkg::WINDOW_W-1:0] window_tmr_ff;
   logic [rklm_pkg::WINDOW_W-1:0] window_tmr_in;
   rklm_pkg::rsp_type             rsp_ff;
   rklm_pkg::rsp_type             rsp_in;

   // helpers for the commit step
   logic [rklm_pkg::KEY_W-1:0]    frame_key;
   logic [3:0]                    cmd_nib;
   logic                          hit;
   logic                          any_key;
   logic [rklm_pkg::IDX_W-1:0]    count_clamp;
   logic [rklm_pkg::FRAME_W-1:0]  first;
   logic                          same;
   logic [rklm_pkg::KEY_W-1:0]    hist_key;
   logic [rklm_pkg::KEY_W-1:0]    prev_key;
   logic [rklm_pkg::IDX_W-1:0]    index_next;
   logic                          finish;

   // checksum: low byte equals the 8-bit sum of the upper bytes
   assign sum8       = req_ff.frame[31:24] + req_ff.frame[23:16] + req_ff.frame[15:8];
   assign checked_in = (sum8 == req_ff.frame[7:0]) ? req_ff.frame : '0;

   // commit step: one transaction's state update and result
   always_comb begin
      key_tab_in    = key_tab_ff;
      hist_in       = hist_ff;
      target_in     = target_ff;
      index_in      = index_ff;
      learning_in   = learning_ff;
      motor_busy_in = motor_busy_ff;
      prompt_tmr_in = prompt_tmr_ff;
      window_tmr_in = window_tmr_ff;
      rsp_in        = '0;
      finish        = 1'b0;

      frame_key = checked_ff[rklm_pkg::FRAME_W-1 -: rklm_pkg::KEY_W];
      cmd_nib   = checked_ff[rklm_pkg::CMD_LSB +: 4];

      // key match and occupancy over all slots
      hit     = 1'b0;
      any_key = 1'b0;
      for (int i = 0; i < rklm_pkg::KEY_SLOTS; i++) begin
         if (key_tab_ff[i] == frame_key) hit = 1'b1;
         if (key_tab_ff[i] != '0) any_key = 1'b1;
      end

      // learn count clamped to the slot count
      if (req_ff.learn_count > 8'(rklm_pkg::KEY_SLOTS)) begin
         count_clamp = rklm_pkg::IDX_W'(rklm_pkg::KEY_SLOTS);
      end else begin
         count_clamp = rklm_pkg::IDX_W'(req_ff.learn_count);
      end

      // shifted history with the new frame at the end
      for (int i = 0; i < rklm_pkg::REPEAT_FRAMES - 1; i++) begin
         hist_in[i] = hist_ff[i + 1];
      end
      hist_in[rklm_pkg::REPEAT_FRAMES - 1] = checked_ff;
      first = hist_in[0];
      same  = 1'b1;
      for (int i = 1; i < rklm_pkg::REPEAT_FRAMES; i++) begin
         if (hist_in[i] != first) same = 1'b0;
      end
      hist_key = first[rklm_pkg::FRAME_W-1 -: rklm_pkg::KEY_W];

      // key of the slot written just before
      prev_key = '0;
      for (int i = 0; i < rklm_pkg::KEY_SLOTS; i++) begin
         if (rklm_pkg::IDX_W'(i + 1) == index_ff) prev_key = key_tab_ff[i];
      end
      index_next = index_ff + 1'b1;

      if (req_ff.action == rklm_pkg::ACT_MOTOR_DONE) begin
         motor_busy_in = 1'b0;
         hist_in       = hist_ff;
      end else if (!learning_ff) begin
         hist_in = hist_ff;
         if (req_ff.action == rklm_pkg::ACT_FRAME) begin
            // normal operation: matched key drives the lock
            if (hit && !motor_busy_ff) begin
               if (cmd_nib == rklm_pkg::CMD_LOWER &&
                   req_ff.lock_position != rklm_pkg::LOCK_LOWERED) begin
                  rsp_in.motor_command = rklm_pkg::MOTOR_LOWER;
                  rsp_in.beep_pattern  = rklm_pkg::BEEP_ACCEPTED;
                  motor_busy_in        = 1'b1;
               end else if (cmd_nib == rklm_pkg::CMD_RAISE &&
                            req_ff.lock_position != rklm_pkg::LOCK_RAISED) begin
                  rsp_in.motor_command = rklm_pkg::MOTOR_RAISE;
                  rsp_in.beep_pattern  = rklm_pkg::BEEP_ACCEPTED;
                  motor_busy_in        = 1'b1;
               end
            end
         end else if (req_ff.action == rklm_pkg::ACT_LEARN) begin
            // start a learning session
            if (!(req_ff.at_power_up && any_key) && count_clamp != '0) begin
               target_in     = count_clamp;
               index_in      = '0;
               for (int i = 0; i < rklm_pkg::REPEAT_FRAMES; i++) begin
                  hist_in[i] = rklm_pkg::FRAME_W'(i + 1);
               end
               prompt_tmr_in = prompt_int_ff;
               window_tmr_in = window_len_ff;
               learning_in   = 1'b1;
            end
         end
      end else if (req_ff.action == rklm_pkg::ACT_FRAME) begin
         // learning: store after enough identical frames
         if (same && first != '0 && index_ff < rklm_pkg::IDX_W'(rklm_pkg::KEY_SLOTS) &&
             !(index_ff != '0 && prev_key == hist_key)) begin
            for (int i = 0; i < rklm_pkg::KEY_SLOTS; i++) begin
               if (rklm_pkg::IDX_W'(i) == index_ff) key_tab_in[i] = hist_key;
            end
            rsp_in.key_learned  = 1'b1;
            rsp_in.learned_slot = 3'(index_ff);
            rsp_in.beep_pattern = rklm_pkg::BEEP_LEARNED;
            prompt_tmr_in       = prompt_int_ff;
            index_in            = index_next;
            if (index_next >= target_ff ||
                index_next >= rklm_pkg::IDX_W'(rklm_pkg::KEY_SLOTS)) begin
               finish = 1'b1;
            end
         end
      end else begin
         hist_in = hist_ff;
         if (req_ff.action == rklm_pkg::ACT_TICK) begin
            // prompt timer
            if (prompt_tmr_ff <= rklm_pkg::PROMPT_W'(1)) begin
               prompt_tmr_in       = prompt_int_ff;
               rsp_in.beep_pattern = rklm_pkg::BEEP_PROMPT;
            end else begin
               prompt_tmr_in = prompt_tmr_ff - 1'b1;
            end
            // window timer, wins over the prompt
            if (window_tmr_ff <= rklm_pkg::WINDOW_W'(1)) begin
               window_tmr_in = window_len_ff;
               finish        = 1'b1;
            end else begin
               window_tmr_in = window_tmr_ff - 1'b1;
            end
         end
      end

      // end of session: clear the slots above the target
      if (finish) begin
         for (int i = 0; i < rklm_pkg::KEY_SLOTS; i++) begin
            if (rklm_pkg::IDX_W'(i) >= target_ff) key_tab_in[i] = '0;
         end
         learning_in         = 1'b0;
         rsp_in.beep_pattern = rklm_pkg::BEEP_OVER;
      end

      rsp_in.learning_active = learning_in;
      rsp_in.keys_learned    = 3'(index_in);
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         prompt_int_ff <= rklm_pkg::PROMPT_RESET;
         window_len_ff <= rklm_pkg::WINDOW_RESET;
         for (int i = 0; i < rklm_pkg::KEY_SLOTS; i++) begin
            key_tab_ff[i] <= '0;
         end
         for (int i = 0; i < rklm_pkg::REPEAT_FRAMES; i++) begin
            hist_ff[i] <= rklm_pkg::FRAME_W'(i + 1);
         end
         target_ff     <= '0;
         index_ff      <= '0;
         learning_ff   <= 1'b0;
         motor_busy_ff <= 1'b0;
         prompt_tmr_ff <= '0;
         window_tmr_ff <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               rklm_pkg::REG_PROMPT: prompt_int_ff <= csr_wdata[rklm_pkg::PROMPT_W-1:0];
               rklm_pkg::REG_WINDOW: window_len_ff <= csr_wdata[rklm_pkg::WINDOW_W-1:0];
               default: ;
            endcase
         end
         if (cmd.commit) begin
            key_tab_ff    <= key_tab_in;
            hist_ff       <= hist_in;
            target_ff     <= target_in;
            index_ff      <= index_in;
            learning_ff   <= learning_in;
            motor_busy_ff <= motor_busy_in;
            prompt_tmr_ff <= prompt_tmr_in;
            window_tmr_ff <= window_tmr_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load)   req_ff     <= req_data;
      if (cmd.check)  checked_ff <= checked_in;
      if (cmd.commit) rsp_ff     <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

>>> rtl/core/rklm_port_check.sv
// rklm_port_check: port-level assertions for the learning remote key decoder
// depends on rklm_pkg; bound to remote_key_learn_and_match_core
`timescale 1ns / 1ps

module rklm_port_check (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rklm_pkg::rsp_type rsp_data
);

   // a held result stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // a held result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("result changed while stalled");

   // one transaction at a time: input closes right after an accept
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted while a transaction is in flight");

   // a fresh result follows an accept by way of the check and commit states
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 3))
      else $error("result without a matching transaction");

endmodule

bind remote_key_learn_and_match_core rklm_port_check u_port_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> tb/remote_key_learn_and_match_core_tb.sv
// remote_key_learn_and_match_core_tb: self-checking bench for the learning remote key decoder
// depends on rklm_pkg and remote_key_learn_and_match_core; predicts each response in a scoreboard
`timescale 1ns / 1ps

module remote_key_learn_and_match_core_tb;
   import rklm_pkg::*;

   localparam int PHASE_ITEMS  = 385;
   localparam int NUM_PHASES   = 5;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 600000;

   // expected-response store plus a bit-accurate copy of the decoder state
   class lock_decoder_scoreboard;
      rsp_type             expected_responses[$];
      int unsigned         failures;
      logic [PROMPT_W-1:0] prompt_interval;
      logic [WINDOW_W-1:0] window_length;
      logic [KEY_W-1:0]    key_table[KEY_SLOTS];
      logic [FRAME_W-1:0]  frame_history[REPEAT_FRAMES];
      int unsigned         learn_target;
      int unsigned         learn_index;
      int unsigned         prompt_timer;
      int unsigned         window_timer;
      bit                  learning;
      bit                  motor_busy;

      function new();
         failures        = 0;
         prompt_interval = PROMPT_RESET;
         window_length   = WINDOW_RESET;
         foreach (key_table[i]) key_table[i] = '0;
         restart_history();
         learn_target = 0;
         learn_index  = 0;
         prompt_timer = 0;
         window_timer = 0;
         learning     = 1'b0;
         motor_busy   = 1'b0;
      endfunction

      function void restart_history();
         foreach (frame_history[i]) frame_history[i] = FRAME_W'(i + 1);
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] reg_index,
                                   logic [CSR_DATA_W-1:0] data);
         if (reg_index == REG_PROMPT) begin
            prompt_interval = data[PROMPT_W-1:0];
         end else if (reg_index == REG_WINDOW) begin
            window_length = data[WINDOW_W-1:0];
         end
      endfunction

      // frame with a bad checksum byte reads as zero
      function logic [FRAME_W-1:0] checked(logic [FRAME_W-1:0] f);
         logic [7:0] sum;
         sum = f[31:24] + f[23:16] + f[15:8];
         return (sum == f[7:0]) ? f : '0;
      endfunction

      function bit timer_expired(inout int unsigned t, input int unsigned reload);
         if (t <= 1) begin
            t = reload;
            return 1'b1;
         end
         t = t - 1;
         return 1'b0;
      endfunction

      // clear slots past the target and leave learning
      function void finish_session();
         for (int i = learn_target; i < KEY_SLOTS; i++) key_table[i] = '0;
         learning = 1'b0;
      endfunction

      function void note_request(req_type r);
         rsp_type              rsp;
         logic [FRAME_W-1:0]   code;
         logic [KEY_W-1:0]     key;
         logic [3:0]           cmd;
         bit                   hit;
         bit                   any_key;
         bit                   same;
         int unsigned          count;
         rsp = '0;
         if (r.action == ACT_MOTOR_DONE) begin
            motor_busy = 1'b0;
         end else if (!learning) begin
            if (r.action == ACT_FRAME) begin
               // key match and lock command
               code = checked(r.frame);
               key  = code[FRAME_W-1 -: KEY_W];
               cmd  = code[CMD_LSB +: 4];
               hit  = 1'b0;
               foreach (key_table[i]) if (key_table[i] == key) hit = 1'b1;
               if (hit && !motor_busy) begin
                  if (cmd == CMD_LOWER && r.lock_position != LOCK_LOWERED) begin
                     rsp.motor_command = MOTOR_LOWER;
                     rsp.beep_pattern  = BEEP_ACCEPTED;
                     motor_busy        = 1'b1;
                  end else if (cmd == CMD_RAISE && r.lock_position != LOCK_RAISED) begin
                     rsp.motor_command = MOTOR_RAISE;
                     rsp.beep_pattern  = BEEP_ACCEPTED;
                     motor_busy        = 1'b1;
                  end
               end
            end else if (r.action == ACT_LEARN) begin
               // learn request, refused at power-up when any slot is taken
               any_key = 1'b0;
               foreach (key_table[i]) if (key_table[i] != '0) any_key = 1'b1;
               count = (r.learn_count > KEY_SLOTS) ? KEY_SLOTS : r.learn_count;
               if (!(r.at_power_up && any_key) && count != 0) begin
                  learn_target = count;
                  learn_index  = 0;
                  restart_history();
                  prompt_timer = prompt_interval;
                  window_timer = window_length;
                  learning     = 1'b1;
               end
            end
         end else if (r.action == ACT_FRAME) begin
            // learning: store after a run of identical nonzero frames
            for (int i = 0; i < REPEAT_FRAMES - 1; i++) frame_history[i] = frame_history[i + 1];
            frame_history[REPEAT_FRAMES - 1] = checked(r.frame);
            same = 1'b1;
            for (int i = 1; i < REPEAT_FRAMES; i++)
               if (frame_history[i] != frame_history[0]) same = 1'b0;
            key = frame_history[0][FRAME_W-1 -: KEY_W];
            if (same && frame_history[0] != '0 && learn_index < KEY_SLOTS &&
                !(learn_index != 0 && key_table[learn_index - 1] == key)) begin
               key_table[learn_index] = key;
               rsp.key_learned        = 1'b1;
               rsp.learned_slot       = 3'(learn_index);
               rsp.beep_pattern       = BEEP_LEARNED;
               prompt_timer           = prompt_interval;
               learn_index            = learn_index + 1;
               if (learn_index >= learn_target || learn_index >= KEY_SLOTS) begin
                  finish_session();
                  rsp.beep_pattern = BEEP_OVER;
               end
            end
         end else if (r.action == ACT_TICK) begin
            // prompt and window timers, window expiry wins
            if (timer_expired(prompt_timer, prompt_interval)) rsp.beep_pattern = BEEP_PROMPT;
            if (timer_expired(window_timer, window_length)) begin
               finish_session();
               rsp.beep_pattern = BEEP_OVER;
            end
         end
         rsp.learning_active = learning;
         rsp.keys_learned    = 3'(learn_index);
         expected_responses.push_back(rsp);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            failures++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_responses.size() == 0) begin
            failures++;
            $display("%0t: response with nothing expected, expected none, actual %h",
                     $realtime, got);
            return;
         end
         want = expected_responses.pop_front();
         compare_field("motor_command", want.motor_command, got.motor_command);
         compare_field("beep_pattern", want.beep_pattern, got.beep_pattern);
         compare_field("learning_active", want.learning_active, got.learning_active);
         compare_field("key_learned", want.key_learned, got.key_learned);
         compare_field("learned_slot", want.learned_slot, got.learned_slot);
         compare_field("keys_learned", want.keys_learned, got.keys_learned);
      endfunction
   endclass

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   lock_decoder_scoreboard sb = new();
   int unsigned            items_sent  = 0;
   int unsigned            cycle_count = 0;
   int unsigned            hold_cycles = 0;
   bit                     idle_on     = 1'b1;
   logic [KEY_W-1:0]       key_pool[6];

   remote_key_learn_and_match_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // response side: random or long hold-off, then take one transaction
   initial begin
      int unsigned n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_cycles > 0) begin
            n           = hold_cycles;
            hold_cycles = 0;
         end else begin
            n = idle_on ? $urandom_range(0, 7) : 0;
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         sb.check_response(rsp_data);
      end
   end

   // valid frame: key, command nibble, checksum byte
   function automatic logic [FRAME_W-1:0] coded_frame(logic [KEY_W-1:0] key, logic [3:0] cmd);
      logic [FRAME_W-1:0] f;
      f      = {key, cmd, 8'h00};
      f[7:0] = f[31:24] + f[23:16] + f[15:8];
      return f;
   endfunction

   function automatic req_type random_request();
      req_type r;
      r.action        = 2'($urandom_range(0, 3));
      r.frame         = $urandom;
      r.lock_position = 2'($urandom_range(0, 3));
      r.at_power_up   = 1'($urandom_range(0, 1));
      r.learn_count   = 8'($urandom_range(0, 255));
      return r;
   endfunction

   function automatic req_type make_req(logic [1:0] action, logic [FRAME_W-1:0] frame,
                                        logic [1:0] lock, logic pu, logic [7:0] count);
      req_type r;
      r.action        = action;
      r.frame         = frame;
      r.lock_position = lock;
      r.at_power_up   = pu;
      r.learn_count   = count;
      return r;
   endfunction

   function automatic logic [KEY_W-1:0] pick_key();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel < 4) return sb.key_table[$urandom_range(0, KEY_SLOTS - 1)];
      if (sel < 9) return key_pool[$urandom_range(0, 5)];
      return KEY_W'($urandom);
   endfunction

   function automatic logic [3:0] pick_command();
      case ($urandom_range(0, 2))
         0: return CMD_LOWER;
         1: return CMD_RAISE;
         default: return 4'($urandom_range(0, 15));
      endcase
   endfunction

   // one request transaction, held until accepted
   task automatic send(req_type r);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_responses.size() != 0) @(posedge clock);
   endtask

   // both registers, written only with the block idle
   task automatic configure(logic [CSR_DATA_W-1:0] prompt, logic [CSR_DATA_W-1:0] window);
      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= REG_PROMPT;
      csr_wdata <= prompt;
      @(posedge clock);
      sb.write_register(REG_PROMPT, prompt);
      csr_index <= REG_WINDOW;
      csr_wdata <= window;
      @(posedge clock);
      sb.write_register(REG_WINDOW, window);
      csr_we <= 1'b0;
   endtask

   task automatic send_frames(logic [FRAME_W-1:0] f, int unsigned n);
      req_type r;
      for (int i = 0; i < n; i++) begin
         r        = random_request();
         r.action = ACT_FRAME;
         r.frame  = f;
         send(r);
      end
   endtask

   task automatic send_ticks(int unsigned n);
      req_type r;
      for (int i = 0; i < n; i++) begin
         r        = random_request();
         r.action = ACT_TICK;
         send(r);
      end
   endtask

   // learn request followed by runs of repeated frames, ticks and noise
   task automatic learn_session();
      req_type          r;
      logic [KEY_W-1:0] key;
      int unsigned      sel;
      int unsigned      guard;
      r             = random_request();
      r.action      = ACT_LEARN;
      r.at_power_up = ($urandom_range(0, 3) == 0);
      r.learn_count = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(1, KEY_SLOTS));
      send(r);
      guard = 0;
      while (sb.learning && guard < 60) begin
         guard++;
         sel = $urandom_range(0, 99);
         if (sel < 8) begin
            send_ticks(($urandom_range(0, 19) == 0) ? $urandom_range(10, 80)
                                                    : $urandom_range(1, 4));
         end else if (sel < 14) begin
            r        = random_request();
            r.action = ACT_FRAME;
            send(r);
         end else if (sel < 18) begin
            r        = random_request();
            r.action = ACT_MOTOR_DONE;
            send(r);
         end else begin
            if (sb.learn_index != 0 && $urandom_range(0, 6) == 0)
               key = sb.key_table[sb.learn_index - 1];
            else
               key = key_pool[$urandom_range(0, 5)];
            send_frames(coded_frame(key, 4'($urandom_range(0, 15))),
                        ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : REPEAT_FRAMES);
            if ($urandom_range(0, 9) == 0) send_ticks(1);
         end
      end
   endtask

   // key matching with motor commands
   task automatic match_burst();
      req_type     r;
      int unsigned sel;
      repeat ($urandom_range(4, 12)) begin
         r   = random_request();
         sel = $urandom_range(0, 99);
         if (sel < 60) begin
            r.action = ACT_FRAME;
            r.frame  = coded_frame(pick_key(), pick_command());
         end else if (sel < 85) begin
            r.action = ACT_MOTOR_DONE;
         end else if (sel < 95) begin
            r.action = ACT_TICK;
         end
         send(r);
      end
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] phase_prompt[NUM_PHASES];
      logic [CSR_DATA_W-1:0] phase_window[NUM_PHASES];
      int unsigned           phase_end;
      int unsigned           next_idle_change;
      int unsigned           sel;
      bit                    paused;
      req_type               r;

      key_pool[0] = '0;
      for (int i = 1; i < 6; i++) key_pool[i] = KEY_W'($urandom);
      phase_prompt = '{1, 255, 10, $urandom_range(1, 255), 3};
      phase_window = '{1, 1023, 60, $urandom_range(1, 1023), 20};

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: matching against empty slots, motor busy, lock positions
      configure(2, 4);
      send(make_req(ACT_FRAME, coded_frame('0, CMD_LOWER), 2'd0, 1'b1, 8'd0));
      send(make_req(ACT_FRAME, coded_frame('0, CMD_RAISE), 2'd0, 1'b0, 8'd0));
      send(make_req(ACT_MOTOR_DONE, '0, 2'd0, 1'b0, 8'd0));
      send(make_req(ACT_FRAME, coded_frame('0, CMD_LOWER), LOCK_LOWERED, 1'b0, 8'd0));
      send(make_req(ACT_FRAME, coded_frame('0, CMD_RAISE), LOCK_RAISED, 1'b0, 8'd0));
      send(make_req(ACT_FRAME, coded_frame('0, CMD_RAISE), 2'd3, 1'b0, 8'd255));
      send(make_req(ACT_MOTOR_DONE, '1, 2'd3, 1'b1, 8'd255));
      send(make_req(ACT_FRAME, '1, 2'd0, 1'b0, 8'd0));
      send(make_req(ACT_FRAME, coded_frame('1, 4'hf), 2'd0, 1'b0, 8'd0));
      // directed: learn requests, timers with both expiring on one tick
      send(make_req(ACT_LEARN, '0, 2'd0, 1'b0, 8'd0));
      send(make_req(ACT_LEARN, '0, 2'd0, 1'b1, 8'd200));
      send(make_req(ACT_LEARN, '0, 2'd0, 1'b0, 8'd3));
      send_ticks(4);
      // directed: two keys, a repeat of the previous slot, refused power-up start
      send(make_req(ACT_LEARN, '0, 2'd0, 1'b0, 8'd2));
      send_frames(coded_frame(20'habcde, CMD_LOWER), REPEAT_FRAMES + 1);
      send_frames(coded_frame(20'h12345, CMD_RAISE), REPEAT_FRAMES);
      send(make_req(ACT_LEARN, '0, 2'd0, 1'b1, 8'd5));
      send(make_req(ACT_FRAME, coded_frame(20'h12345, CMD_LOWER), 2'd0, 1'b0, 8'd0));

      // random phases over several register settings
      next_idle_change = 0;
      for (int p = 0; p < NUM_PHASES; p++) begin
         configure(phase_prompt[p], phase_window[p]);
         if (p == 1) hold_cycles = 150;
         phase_end = items_sent + PHASE_ITEMS;
         paused    = 1'b0;
         while (items_sent < phase_end) begin
            if (p == 2 && !paused && items_sent + PHASE_ITEMS / 2 > phase_end) begin
               drain();
               paused = 1'b1;
            end
            if (items_sent >= next_idle_change) begin
               idle_on          = ($urandom_range(0, 3) != 0);
               next_idle_change = items_sent + 48;
            end
            sel = $urandom_range(0, 9);
            if (sel < 3) begin
               learn_session();
            end else if (sel < 8) begin
               match_burst();
            end else begin
               repeat ($urandom_range(1, 4)) begin
                  r = random_request();
                  send(r);
               end
            end
         end
      end

      drain();
      repeat (DRAIN_CYCLES * 2) @(posedge clock);
      if (sb.failures == 0 && sb.expected_responses.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/rklm_pkg.sv
rtl/core/rklm_ctrl.sv
rtl/core/rklm_dp.sv
rtl/core/remote_key_learn_and_match_core.sv
rtl/core/rklm_port_check.sv
tb/remote_key_learn_and_match_core_tb.sv
